// ===== rtl/vks_pkg.sv =====
// vks_pkg: shared constants, types and tables of the vehicle kinematic step block
// used by vks_cordic, vks_div, the bench and vehicle_kinematic_step
// no dependencies
`default_nettype none

package vks_pkg;

  // fixed point format
  localparam int FracBits = 16;
  localparam longint One = longint'(1) << FracBits;

  // thresholds and battery levels
  localparam longint ThCmd     = (One + 50) / 100;
  localparam longint ThSnap    = (One * 5 + 50) / 100;
  localparam longint ThSteer   = (One + 500) / 1000;
  localparam longint BattMin   = One * 9;
  localparam longint BattReset = (One * 126 + 5) / 10;
  localparam longint DrainDiv  = 100 * One;

  // drain divide by 100 after dropping the fraction: exact for up to 21-bit numerators
  localparam longint DrainRecip = 2684355;
  localparam int     DrainShift = 28;

  // angle constants
  localparam longint Pi32     = 64'sd13493037705;
  localparam longint PiF      = (Pi32 + (longint'(1) << (31 - FracBits))) >>> (32 - FracBits);
  localparam longint Pi30     = 64'sd3373259426;
  localparam longint HalfPi30 = 64'sd1686629713;
  localparam longint CordicK  = 64'sd652032874;
  localparam int     CordicIters = 24;
  localparam longint TanMax   = longint'(1) << 40;

  // divider quotient lengths
  localparam int QLong  = 41;
  localparam int QShort = 18;

  // configuration port
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 21;
  localparam logic [CfgIdxW-1:0] CfgWheelBase  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgSpeedLimit = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgAccelLimit = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSteerLimit = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSlewRate   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTimeStep   = 3'd5;

  // register reset values
  localparam longint WbReset    = 19661;
  localparam longint VmaxReset  = 196608;
  localparam longint AlReset    = 131072;
  localparam longint SlReset    = 39322;
  localparam longint SlewReset  = 163840;
  localparam longint DtReset    = 655;

  // sequencer states
  typedef enum logic [4:0] {
    ST_IDLE, ST_TGT, ST_SLEW, ST_STEER, ST_ACCEL, ST_DV, ST_SPEED, ST_SD, ST_SDR,
    ST_DRN, ST_SCOR, ST_SCORW, ST_TAN, ST_TANW, ST_TM0, ST_TM1, ST_TM2, ST_DH,
    ST_DHW, ST_WRAP, ST_HCOR, ST_HCORW, ST_DX, ST_DY, ST_YU, ST_BATW, ST_DONE
  } vks_state_e;

  // divider request and response
  typedef struct packed {
    logic        start;
    logic        long_mode;
    logic [63:0] num;
    logic [31:0] den;
  } vks_div_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [QLong-1:0]  quo;
  } vks_div_rsp_t;

  // rotator request and response
  typedef struct packed {
    logic               start;
    logic signed [18:0] angle;
  } vks_cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [32:0] cos_q30;
    logic signed [32:0] sin_q30;
  } vks_cordic_rsp_t;

  // arctangent of 2^-i in Q2.30
  function automatic logic [30:0] atan_q30(input logic [4:0] idx);
    logic [30:0] v;
    case (idx)
      5'd0:  v = 31'd843314857;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043837;
      5'd3:  v = 31'd133525159;
      5'd4:  v = 31'd67021687;
      5'd5:  v = 31'd33543516;
      5'd6:  v = 31'd16775851;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194283;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048576;
      5'd11: v = 31'd524288;
      5'd12: v = 31'd262144;
      5'd13: v = 31'd131072;
      5'd14: v = 31'd65536;
      5'd15: v = 31'd32768;
      5'd16: v = 31'd16384;
      5'd17: v = 31'd8192;
      5'd18: v = 31'd4096;
      5'd19: v = 31'd2048;
      5'd20: v = 31'd1024;
      5'd21: v = 31'd512;
      5'd22: v = 31'd256;
      5'd23: v = 31'd128;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/vks_in_if.sv =====
// vks_in_if: command channel, one item per tick
// valid/ready handshake, no dependencies
`default_nettype none

interface vks_in_if;
  logic               valid;
  logic               ready;
  logic signed [17:0] speed_command;
  logic signed [17:0] steer_command;

  modport source (output valid, output speed_command, output steer_command, input ready);
  modport sink   (input valid, input speed_command, input steer_command, output ready);
endinterface

`default_nettype wire

// ===== rtl/vks_out_if.sv =====
// vks_out_if: vehicle state channel, one item per tick
// valid/ready handshake, no dependencies
`default_nettype none

interface vks_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [18:0] heading_out;
  logic signed [21:0] speed_out;
  logic signed [17:0] steer_angle_out;
  logic        [19:0] battery_out;

  modport source (output valid, output pos_x, output pos_y, output heading_out,
                  output speed_out, output steer_angle_out, output battery_out,
                  input ready);
  modport sink   (input valid, input pos_x, input pos_y, input heading_out,
                  input speed_out, input steer_angle_out, input battery_out,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/vks_cordic.sv =====
// vks_cordic: iterative rotation unit, one micro-rotation per cycle
// depends on vks_pkg (angle constants, atan table, request/response types)
`default_nettype none

module vks_cordic (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  vks_pkg::vks_cordic_req_t req_i,
  output vks_pkg::vks_cordic_rsp_t rsp_o
);

  localparam logic signed [33:0] HalfPi = 34'(vks_pkg::HalfPi30);
  localparam logic signed [33:0] Pi     = 34'(vks_pkg::Pi30);
  localparam logic [4:0]         LastIt = 5'(vks_pkg::CordicIters - 1);

  logic               busy_q, done_q, neg_q;
  logic [4:0]         it_q;
  logic signed [32:0] x_q, y_q, x_d, y_d, xs, ys;
  logic signed [33:0] z_q, z_d, z0, z_fold, at;
  logic               neg0;

  // angle to Q2.30 and fold into the right half plane
  always_comb begin
    z0 = 34'(req_i.angle) <<< (30 - vks_pkg::FracBits);
    neg0 = 1'b0;
    z_fold = z0;
    if (z0 > HalfPi) begin
      z_fold = z0 - Pi;
      neg0 = 1'b1;
    end else if (z0 < -HalfPi) begin
      z_fold = z0 + Pi;
      neg0 = 1'b1;
    end
  end

  // one micro-rotation
  always_comb begin
    xs = x_q >>> it_q;
    ys = y_q >>> it_q;
    at = $signed(34'(vks_pkg::atan_q30(it_q)));
    if (z_q >= 0) begin
      x_d = x_q - ys;
      y_d = y_q + xs;
      z_d = z_q - at;
    end else begin
      x_d = x_q + ys;
      y_d = y_q - xs;
      z_d = z_q + at;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
      end else if (busy_q && it_q == LastIt) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // rotation registers
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      x_q   <= 33'(vks_pkg::CordicK);
      y_q   <= '0;
      z_q   <= z_fold;
      neg_q <= neg0;
      it_q  <= '0;
    end else if (busy_q) begin
      x_q  <= x_d;
      y_q  <= y_d;
      z_q  <= z_d;
      it_q <= it_q + 5'd1;
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.cos_q30 = neg_q ? -x_q : x_q;
  assign rsp_o.sin_q30 = neg_q ? -y_q : y_q;

endmodule

`default_nettype wire

// ===== rtl/vks_div.sv =====
// vks_div: restoring divider, one quotient bit per cycle, with overflow flag
// depends on vks_pkg (quotient lengths, request/response types)
`default_nettype none

module vks_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  vks_pkg::vks_div_req_t req_i,
  output vks_pkg::vks_div_rsp_t rsp_o
);

  localparam int QL = vks_pkg::QLong;
  localparam int QS = vks_pkg::QShort;

  logic          busy_q, done_q, sat_q;
  logic [5:0]    cnt_q;
  logic [31:0]   rem_q, den_q;
  logic [QL-1:0] lo_q, quo_q;
  logic [63:0]   hi;
  logic          ovf, fits;
  logic [32:0]   trial;

  // quotient would not fit in the requested length
  always_comb begin
    hi  = req_i.long_mode ? (req_i.num >> QL) : (req_i.num >> QS);
    ovf = hi >= 64'(req_i.den);
  end

  // trial subtraction
  always_comb begin
    trial = {rem_q, lo_q[QL-1]};
    fits  = trial >= 33'(den_q);
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sat_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        sat_q <= ovf;
        if (ovf) begin
          done_q <= 1'b1;
          busy_q <= 1'b0;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q && cnt_q == 6'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      den_q <= req_i.den;
      rem_q <= hi[31:0];
      quo_q <= '0;
      if (req_i.long_mode) begin
        lo_q  <= req_i.num[QL-1:0];
        cnt_q <= 6'(QL);
      end else begin
        lo_q  <= {req_i.num[QS-1:0], {(QL-QS){1'b0}}};
        cnt_q <= 6'(QS);
      end
    end else if (busy_q) begin
      rem_q <= fits ? 32'(trial - 33'(den_q)) : trial[31:0];
      quo_q <= {quo_q[QL-2:0], fits};
      lo_q  <= lo_q << 1;
      cnt_q <= cnt_q - 6'd1;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.sat  = sat_q;
  assign rsp_o.quo  = quo_q;

endmodule

`default_nettype wire

// ===== rtl/vehicle_kinematic_step.sv =====
// vehicle_kinematic_step: one tick of a kinematic bicycle model in Q16.16
// depends on vks_pkg, vks_in_if, vks_out_if, vks_cordic, vks_div
//
// Each command item advances steering, speed, heading, position and battery by one
// time step and returns one state item. The block takes one item at a time and holds
// a finished item back while the output register is still full and the receiver stalls.
// Each item runs the 24-step rotator once when the steering angle is near zero
// and twice when turning (for tan), and when turning also the bit-serial divider
// (41 steps for tan, skipped if the cosine is exactly zero, and 18 for yaw), plus
// a short sequence through one shared 33x22 multiplier, which also does the
// battery drain division by a reciprocal product. A finished item sits in an
// output register, so the next command is taken while it waits. Register writes
// go through the plain write port and are meant to happen while idle.
`default_nettype none

module vehicle_kinematic_step (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [vks_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [vks_pkg::CfgDataW-1:0] cfg_data_i,
  vks_in_if.sink                       in_i,
  vks_out_if.source                    out_o
);

  localparam int F = vks_pkg::FracBits;
  localparam logic signed [20:0] PiS     = 21'(vks_pkg::PiF);
  localparam logic [40:0]        TanMaxU = 41'(vks_pkg::TanMax);
  localparam logic [17:0]        PiMag   = 18'(vks_pkg::PiF);

  // configuration registers
  logic [18:0] wb_q;
  logic [20:0] vmax_q, al_q, slew_q;
  logic [16:0] sl_q;
  logic [12:0] dt_q;

  // vehicle state
  logic signed [31:0] x_q, y_q;
  logic signed [18:0] hd_q;
  logic signed [21:0] spd_q;
  logic signed [17:0] st_q;
  logic        [19:0] bat_q;

  // per-item working registers
  vks_pkg::vks_state_e state_q, state_d;
  logic signed [17:0] cmd_q, str_q;
  logic signed [54:0] prod_q, mul_p;
  logic signed [32:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [19:0] tgt_q, sd_q;
  logic signed [23:0] acc_q;
  logic        [20:0] drn_q;
  logic signed [41:0] tn_q;
  logic signed [63:0] tacc_q;
  logic signed [32:0] p_q;

  // output register
  logic               ovalid_q;
  logic signed [31:0] ox_q, oy_q;
  logic signed [18:0] ohd_q;
  logic signed [21:0] ospd_q;
  logic signed [17:0] ost_q;
  logic        [19:0] obat_q;

  // shared units
  vks_pkg::vks_div_req_t    div_req;
  vks_pkg::vks_div_rsp_t    div_rsp;
  vks_pkg::vks_cordic_req_t cor_req;
  vks_pkg::vks_cordic_rsp_t cor_rsp;

  logic in_fire, out_fire, load_out;

  vks_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req),
    .rsp_o  (cor_rsp)
  );

  vks_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_fire  = in_i.valid && in_i.ready;
  assign out_fire = ovalid_q && out_o.ready;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      vks_pkg::ST_TGT: begin
        mul_a = 33'(str_q);
        mul_b = $signed(22'(sl_q));
      end
      vks_pkg::ST_SLEW: begin
        mul_a = $signed(33'(slew_q));
        mul_b = $signed(22'(dt_q));
      end
      vks_pkg::ST_STEER: begin
        mul_a = 33'(cmd_q);
        mul_b = $signed(22'(al_q));
      end
      vks_pkg::ST_DV: begin
        mul_a = 33'(acc_q);
        mul_b = $signed(22'(dt_q));
      end
      vks_pkg::ST_SD: begin
        mul_a = 33'(spd_q);
        mul_b = $signed(22'(dt_q));
      end
      vks_pkg::ST_SDR: begin
        mul_a = acc_q < 0 ? -33'(acc_q) : 33'(acc_q);
        mul_b = $signed(22'(dt_q));
      end
      vks_pkg::ST_TM0: begin
        mul_a = $signed(33'(tn_q[20:0]));
        mul_b = 22'(sd_q);
      end
      vks_pkg::ST_TM1: begin
        mul_a = 33'($signed(tn_q[41:21]));
        mul_b = 22'(sd_q);
      end
      vks_pkg::ST_DX: begin
        mul_a = cor_rsp.cos_q30;
        mul_b = 22'(sd_q);
      end
      vks_pkg::ST_DY: begin
        mul_a = cor_rsp.sin_q30;
        mul_b = 22'(sd_q);
      end
      vks_pkg::ST_YU: begin
        mul_a = 33'(vks_pkg::DrainRecip);
        mul_b = $signed(22'(drn_q));
      end
      default: ;
    endcase
    mul_p = mul_a * mul_b;
  end

  // steering
  logic signed [19:0] tgt_raw, sl_s, tgt_c;
  logic signed [20:0] md_s, err, err_c;
  logic signed [17:0] st_n;

  always_comb begin
    tgt_raw = $signed(prod_q[F +: 20]);
    sl_s    = $signed(20'(sl_q));
    if (tgt_raw > sl_s) begin
      tgt_c = sl_s;
    end else if (tgt_raw < -sl_s) begin
      tgt_c = -sl_s;
    end else begin
      tgt_c = tgt_raw;
    end
    md_s = $signed(21'(prod_q[F +: 19]));
    err  = 21'(tgt_q) - 21'(st_q);
    if (err > md_s) begin
      err_c = md_s;
    end else if (err < -md_s) begin
      err_c = -md_s;
    end else begin
      err_c = err;
    end
    st_n = 18'(21'(st_q) + err_c);
  end

  // speed
  logic        [18:0] abs_cmd;
  logic        [22:0] abs_spd;
  logic signed [24:0] s1, s2, vmax_s;
  logic signed [23:0] al4;

  always_comb begin
    abs_cmd = cmd_q < 0 ? 19'(-19'(cmd_q)) : 19'(cmd_q);
    abs_spd = spd_q < 0 ? 23'(-23'(spd_q)) : 23'(spd_q);
    al4     = $signed({1'b0, al_q, 2'b00});
    vmax_s  = $signed(25'(vmax_q));
    s1 = 25'(spd_q) + 25'($signed(prod_q[F +: 21]));
    if (cmd_q == 0 && ((acc_q < 0 && s1 < 0) || (acc_q > 0 && s1 > 0))) begin
      s2 = '0;
    end else begin
      s2 = s1;
    end
    if (s2 > vmax_s) begin
      s2 = vmax_s;
    end else if (s2 < -vmax_s) begin
      s2 = -vmax_s;
    end
  end

  // tan, yaw and heading wrap
  logic        [32:0] abs_s, abs_c, abs_p;
  logic        [18:0] abs_st;
  logic        [40:0] tn_mag;
  logic        [17:0] dh_mag;
  logic signed [19:0] dh_s;
  logic signed [20:0] hsum, hwa, hwb;
  logic signed [63:0] tsum;

  always_comb begin
    abs_s  = cor_rsp.sin_q30 < 0 ? 33'(-cor_rsp.sin_q30) : 33'(cor_rsp.sin_q30);
    abs_c  = cor_rsp.cos_q30 < 0 ? 33'(-cor_rsp.cos_q30) : 33'(cor_rsp.cos_q30);
    abs_p  = p_q < 0 ? 33'(-p_q) : 33'(p_q);
    abs_st = st_q < 0 ? 19'(-19'(st_q)) : 19'(st_q);
    tn_mag = (div_rsp.sat || div_rsp.quo > TanMaxU) ? TanMaxU : div_rsp.quo;
    dh_mag = (div_rsp.sat || div_rsp.quo > 41'(PiMag)) ? PiMag : div_rsp.quo[17:0];
    dh_s   = p_q < 0 ? -20'(dh_mag) : 20'(dh_mag);
    tsum   = tacc_q + (64'(prod_q) <<< 21);
    if (state_q == vks_pkg::ST_DHW) begin
      hsum = 21'(hd_q) + 21'(dh_s);
    end else begin
      hsum = 21'(hd_q);
    end
    hwa = hsum > PiS ? hsum - (PiS <<< 1) : hsum;
    hwb = hwa < -PiS ? hwa + (PiS <<< 1) : hwa;
  end

  // position and battery
  logic signed [32:0] xs, ys_sum;
  logic signed [31:0] x_n, y_n;
  logic signed [20:0] bat_n;

  always_comb begin
    xs     = 33'(x_q) + 33'($signed(prod_q[30 +: 25]));
    ys_sum = 33'(y_q) + 33'($signed(prod_q[30 +: 25]));
    if (xs[32] != xs[31]) begin
      x_n = xs[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      x_n = xs[31:0];
    end
    if (ys_sum[32] != ys_sum[31]) begin
      y_n = ys_sum[32] ? 32'sh80000000 : 32'sh7fffffff;
    end else begin
      y_n = ys_sum[31:0];
    end
    bat_n = $signed(21'(bat_q)) - $signed(21'(prod_q[vks_pkg::DrainShift +: 18]));
    if (bat_n < $signed(21'(vks_pkg::BattMin))) begin
      bat_n = $signed(21'(vks_pkg::BattMin));
    end
  end

  // sequencer: next state and unit requests
  always_comb begin
    state_d           = state_q;
    in_i.ready        = 1'b0;
    load_out          = 1'b0;
    div_req.start     = 1'b0;
    div_req.long_mode = 1'b0;
    div_req.num       = '0;
    div_req.den       = '0;
    cor_req.start     = 1'b0;
    cor_req.angle     = hd_q;
    case (state_q)
      vks_pkg::ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid) state_d = vks_pkg::ST_TGT;
      end
      vks_pkg::ST_TGT:   state_d = vks_pkg::ST_SLEW;
      vks_pkg::ST_SLEW:  state_d = vks_pkg::ST_STEER;
      vks_pkg::ST_STEER: state_d = vks_pkg::ST_ACCEL;
      vks_pkg::ST_ACCEL: state_d = vks_pkg::ST_DV;
      vks_pkg::ST_DV:    state_d = vks_pkg::ST_SPEED;
      vks_pkg::ST_SPEED: state_d = vks_pkg::ST_SD;
      vks_pkg::ST_SD:    state_d = vks_pkg::ST_SDR;
      vks_pkg::ST_SDR:   state_d = vks_pkg::ST_DRN;
      vks_pkg::ST_DRN: begin
        if (64'(abs_st) > vks_pkg::ThSteer) begin
          state_d = vks_pkg::ST_SCOR;
        end else begin
          state_d = vks_pkg::ST_WRAP;
        end
      end
      vks_pkg::ST_SCOR: begin
        cor_req.start = 1'b1;
        cor_req.angle = 19'(st_q);
        state_d = vks_pkg::ST_SCORW;
      end
      vks_pkg::ST_SCORW: begin
        if (cor_rsp.done) state_d = vks_pkg::ST_TAN;
      end
      vks_pkg::ST_TAN: begin
        if (cor_rsp.cos_q30 == 0) begin
          state_d = vks_pkg::ST_TM0;
        end else begin
          div_req.start     = 1'b1;
          div_req.long_mode = 1'b1;
          div_req.num       = 64'(abs_s) << 30;
          div_req.den       = 32'(abs_c);
          state_d = vks_pkg::ST_TANW;
        end
      end
      vks_pkg::ST_TANW: begin
        if (div_rsp.done) state_d = vks_pkg::ST_TM0;
      end
      vks_pkg::ST_TM0: state_d = vks_pkg::ST_TM1;
      vks_pkg::ST_TM1: state_d = vks_pkg::ST_TM2;
      vks_pkg::ST_TM2: state_d = vks_pkg::ST_DH;
      vks_pkg::ST_DH: begin
        div_req.start = 1'b1;
        div_req.num   = 64'(abs_p) << F;
        div_req.den   = (wb_q == '0) ? 32'd1 : 32'(wb_q);
        state_d = vks_pkg::ST_DHW;
      end
      vks_pkg::ST_DHW: begin
        if (div_rsp.done) state_d = vks_pkg::ST_HCOR;
      end
      vks_pkg::ST_WRAP: state_d = vks_pkg::ST_HCOR;
      vks_pkg::ST_HCOR: begin
        cor_req.start = 1'b1;
        state_d = vks_pkg::ST_HCORW;
      end
      vks_pkg::ST_HCORW: begin
        if (cor_rsp.done) state_d = vks_pkg::ST_DX;
      end
      vks_pkg::ST_DX:   state_d = vks_pkg::ST_DY;
      vks_pkg::ST_DY:   state_d = vks_pkg::ST_YU;
      vks_pkg::ST_YU:   state_d = vks_pkg::ST_BATW;
      vks_pkg::ST_BATW: state_d = vks_pkg::ST_DONE;
      vks_pkg::ST_DONE: begin
        if (!ovalid_q || out_o.ready) begin
          load_out = 1'b1;
          state_d  = vks_pkg::ST_IDLE;
        end
      end
      default: state_d = vks_pkg::ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vks_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q   <= 19'(vks_pkg::WbReset);
      vmax_q <= 21'(vks_pkg::VmaxReset);
      al_q   <= 21'(vks_pkg::AlReset);
      sl_q   <= 17'(vks_pkg::SlReset);
      slew_q <= 21'(vks_pkg::SlewReset);
      dt_q   <= 13'(vks_pkg::DtReset);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        vks_pkg::CfgWheelBase:  wb_q   <= cfg_data_i[18:0];
        vks_pkg::CfgSpeedLimit: vmax_q <= cfg_data_i[20:0];
        vks_pkg::CfgAccelLimit: al_q   <= cfg_data_i[20:0];
        vks_pkg::CfgSteerLimit: sl_q   <= cfg_data_i[16:0];
        vks_pkg::CfgSlewRate:   slew_q <= cfg_data_i[20:0];
        vks_pkg::CfgTimeStep:   dt_q   <= cfg_data_i[12:0];
        default: ;
      endcase
    end
  end

  // vehicle state updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q   <= '0;
      y_q   <= '0;
      hd_q  <= '0;
      spd_q <= '0;
      st_q  <= '0;
      bat_q <= 20'(vks_pkg::BattReset);
    end else begin
      case (state_q)
        vks_pkg::ST_STEER: st_q <= st_n;
        vks_pkg::ST_ACCEL: begin
          if (64'(abs_cmd) <= vks_pkg::ThCmd && 64'(abs_spd) <= vks_pkg::ThSnap) begin
            spd_q <= '0;
          end
        end
        vks_pkg::ST_SPEED: spd_q <= 22'(s2);
        vks_pkg::ST_DHW: begin
          if (div_rsp.done) hd_q <= 19'(hwb);
        end
        vks_pkg::ST_WRAP: hd_q <= 19'(hwb);
        vks_pkg::ST_DY:   x_q <= x_n;
        vks_pkg::ST_YU:   y_q <= y_n;
        vks_pkg::ST_BATW: bat_q <= 20'(bat_n);
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    if (in_fire) begin
      cmd_q <= in_i.speed_command;
      str_q <= in_i.steer_command;
    end
    case (state_q)
      vks_pkg::ST_SLEW: tgt_q <= tgt_c;
      vks_pkg::ST_ACCEL: begin
        if (64'(abs_cmd) > vks_pkg::ThCmd) begin
          acc_q <= $signed(prod_q[F +: 24]);
        end else if (64'(abs_spd) > vks_pkg::ThSnap) begin
          acc_q <= spd_q > 0 ? -al4 : al4;
        end else begin
          acc_q <= '0;
        end
      end
      vks_pkg::ST_SDR: sd_q <= $signed(prod_q[F +: 20]);
      // drain numerator with the fraction dropped
      vks_pkg::ST_DRN: drn_q <= prod_q[F +: 21];
      vks_pkg::ST_TAN: begin
        if (cor_rsp.cos_q30 == 0) begin
          tn_q <= cor_rsp.sin_q30 >= 0 ? $signed(42'(TanMaxU)) : -$signed(42'(TanMaxU));
        end
      end
      vks_pkg::ST_TANW: begin
        if (cor_rsp.sin_q30[32] ^ cor_rsp.cos_q30[32]) begin
          tn_q <= -$signed(42'(tn_mag));
        end else begin
          tn_q <= $signed(42'(tn_mag));
        end
      end
      vks_pkg::ST_TM1: tacc_q <= 64'(prod_q);
      vks_pkg::ST_TM2: p_q <= $signed(tsum[30 +: 33]);
      default: ;
    endcase
  end

  // output item register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (load_out) begin
      ovalid_q <= 1'b1;
    end else if (out_fire) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      ox_q   <= x_q;
      oy_q   <= y_q;
      ohd_q  <= hd_q;
      ospd_q <= spd_q;
      ost_q  <= st_q;
      obat_q <= bat_q;
    end
  end

  assign out_o.valid           = ovalid_q;
  assign out_o.pos_x           = ox_q;
  assign out_o.pos_y           = oy_q;
  assign out_o.heading_out     = ohd_q;
  assign out_o.speed_out       = ospd_q;
  assign out_o.steer_angle_out = ost_q;
  assign out_o.battery_out     = obat_q;

endmodule

`default_nettype wire

// ===== dv/tb_vehicle_kinematic_step.sv =====
// tb_vehicle_kinematic_step: self-checking bench for the vehicle kinematic step block
// predicts every state item from the commands and compares it field by field
// depends on vks_pkg, vks_in_if, vks_out_if and vehicle_kinematic_step
`default_nettype none

// expected state of the vehicle after one tick
typedef struct {
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [18:0] heading;
  logic signed [21:0] speed;
  logic signed [17:0] steer;
  logic        [19:0] battery;
} veh_state_t;

class vehicle_scoreboard;
  longint axle_len, speed_limit, accel_limit, steer_limit, slew_rate, time_step;
  longint x_pos, y_pos, heading, speed, steer, battery;
  veh_state_t pending[$];
  int errors;

  function new();
    axle_len = vks_pkg::WbReset;     speed_limit = vks_pkg::VmaxReset;
    accel_limit = vks_pkg::AlReset;  steer_limit = vks_pkg::SlReset;
    slew_rate = vks_pkg::SlewReset;  time_step = vks_pkg::DtReset;
    x_pos = 0; y_pos = 0; heading = 0; speed = 0; steer = 0;
    battery = vks_pkg::BattReset;
    errors = 0;
  endfunction

  function void write_reg(logic [vks_pkg::CfgIdxW-1:0] idx, longint val);
    case (idx)
      vks_pkg::CfgWheelBase:  axle_len    = val & 64'h7FFFF;
      vks_pkg::CfgSpeedLimit: speed_limit = val & 64'h1FFFFF;
      vks_pkg::CfgAccelLimit: accel_limit = val & 64'h1FFFFF;
      vks_pkg::CfgSteerLimit: steer_limit = val & 64'h1FFFF;
      vks_pkg::CfgSlewRate:   slew_rate   = val & 64'h1FFFFF;
      vks_pkg::CfgTimeStep:   time_step   = val & 64'h1FFF;
      default: ;
    endcase
  endfunction

  static function longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  static function longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  // rotation mode cordic: angle in Q16 to cos and sin in Q2.30
  static function void rotate(longint ang, output longint c, output longint s);
    longint z, x, y, t;
    bit flip;
    z = ang * (longint'(1) << (30 - vks_pkg::FracBits));
    x = vks_pkg::CordicK; y = 0; flip = 0;
    if (z > vks_pkg::HalfPi30) begin
      z -= vks_pkg::Pi30; flip = 1;
    end else if (z < -vks_pkg::HalfPi30) begin
      z += vks_pkg::Pi30; flip = 1;
    end
    for (int i = 0; i < vks_pkg::CordicIters; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); z -= longint'(vks_pkg::atan_q30(5'(i)));
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); z += longint'(vks_pkg::atan_q30(5'(i)));
      end
      x = t;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function void note_command(logic signed [17:0] spd_cmd, logic signed [17:0] str_cmd);
    longint cmd, str, wb, target, md, accel, sd, c, s, tn, dh, drain;
    veh_state_t e;
    cmd = spd_cmd; str = str_cmd; accel = 0;
    wb = axle_len != 0 ? axle_len : 1;
    // steering slew
    target = clip((str * steer_limit) >>> vks_pkg::FracBits, -steer_limit, steer_limit);
    md = (slew_rate * time_step) >>> vks_pkg::FracBits;
    steer += clip(target - steer, -md, md);
    // longitudinal
    if (mag(cmd) > vks_pkg::ThCmd) accel = (cmd * accel_limit) >>> vks_pkg::FracBits;
    else if (mag(speed) > vks_pkg::ThSnap) accel = speed > 0 ? -4 * accel_limit
                                                             : 4 * accel_limit;
    else speed = 0;
    speed += (accel * time_step) >>> vks_pkg::FracBits;
    if (cmd == 0 && ((accel < 0 && speed < 0) || (accel > 0 && speed > 0))) speed = 0;
    speed = clip(speed, -speed_limit, speed_limit);
    sd = (speed * time_step) >>> vks_pkg::FracBits;
    // yaw
    if (mag(steer) > vks_pkg::ThSteer) begin
      rotate(steer, c, s);
      if (c == 0) tn = s >= 0 ? vks_pkg::TanMax : -vks_pkg::TanMax;
      else tn = clip((s * (longint'(1) << 30)) / c, -vks_pkg::TanMax, vks_pkg::TanMax);
      dh = ((sd * tn) >>> 30) * vks_pkg::One / wb;
      heading += clip(dh, -vks_pkg::PiF, vks_pkg::PiF);
    end
    if (heading > vks_pkg::PiF) heading -= 2 * vks_pkg::PiF;
    if (heading < -vks_pkg::PiF) heading += 2 * vks_pkg::PiF;
    // position
    rotate(heading, c, s);
    x_pos = clip(x_pos + ((sd * c) >>> 30), -64'sd2147483648, 64'sd2147483647);
    y_pos = clip(y_pos + ((sd * s) >>> 30), -64'sd2147483648, 64'sd2147483647);
    // battery
    drain = (mag(accel) * time_step) / vks_pkg::DrainDiv;
    battery -= drain;
    if (battery < vks_pkg::BattMin) battery = vks_pkg::BattMin;
    e.pos_x = x_pos[31:0]; e.pos_y = y_pos[31:0]; e.heading = heading[18:0];
    e.speed = speed[21:0]; e.steer = steer[17:0]; e.battery = battery[19:0];
    pending.push_back(e);
  endfunction

  function void check_state(veh_state_t got);
    veh_state_t e;
    if (pending.size() == 0) begin
      $error("state item with nothing pending");
      errors++;
      return;
    end
    e = pending.pop_front();
    if (got.pos_x !== e.pos_x) begin
      $error("pos_x exp %0d got %0d", e.pos_x, got.pos_x); errors++;
    end
    if (got.pos_y !== e.pos_y) begin
      $error("pos_y exp %0d got %0d", e.pos_y, got.pos_y); errors++;
    end
    if (got.heading !== e.heading) begin
      $error("heading_out exp %0d got %0d", e.heading, got.heading); errors++;
    end
    if (got.speed !== e.speed) begin
      $error("speed_out exp %0d got %0d", e.speed, got.speed); errors++;
    end
    if (got.steer !== e.steer) begin
      $error("steer_angle_out exp %0d got %0d", e.steer, got.steer); errors++;
    end
    if (got.battery !== e.battery) begin
      $error("battery_out exp %0d got %0d", e.battery, got.battery); errors++;
    end
  endfunction
endclass

module tb_vehicle_kinematic_step;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit = 20000;

  logic clk_i, rst_ni;
  logic cfg_we_i;
  logic [vks_pkg::CfgIdxW-1:0]  cfg_idx_i;
  logic [vks_pkg::CfgDataW-1:0] cfg_data_i;
  int send_idle_pct, recv_stall_pct;
  int idle_cycles;
  vehicle_scoreboard sb;

  vks_in_if  cmd_if();
  vks_out_if state_if();

  vehicle_kinematic_step DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(cmd_if.sink), .out_o(state_if.source)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    sb = new();
    rst_ni = 0; cfg_we_i = 0; cfg_idx_i = '0; cfg_data_i = '0;
    cmd_if.valid = 0; cmd_if.speed_command = '0; cmd_if.steer_command = '0;
    state_if.ready = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
  end

  // receiver: random stall, check accepted state items
  always @(posedge clk_i) begin
    veh_state_t got;
    if (rst_ni) begin
      if (state_if.valid && state_if.ready) begin
        got.pos_x = state_if.pos_x; got.pos_y = state_if.pos_y;
        got.heading = state_if.heading_out; got.speed = state_if.speed_out;
        got.steer = state_if.steer_angle_out; got.battery = state_if.battery_out;
        sb.check_state(got);
      end
      state_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles without any accepted item
  always @(posedge clk_i) begin
    if ((cmd_if.valid && cmd_if.ready) || (state_if.valid && state_if.ready))
      idle_cycles <= 0;
    else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end
  initial idle_cycles = 0;

  // valid stays high after an accept until the next command replaces it or an idle gap or drain_block drops it
  task automatic send_command(logic signed [17:0] spd, logic signed [17:0] str);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 0;
      @(posedge clk_i);
    end
    cmd_if.valid <= 1;
    cmd_if.speed_command <= spd;
    cmd_if.steer_command <= str;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    sb.note_command(spd, str);
  endtask

  // wait until every expected state item is back, then let the block settle
  task automatic drain_block();
    cmd_if.valid <= 0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [vks_pkg::CfgIdxW-1:0] idx, longint val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[vks_pkg::CfgDataW-1:0];
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic load_config(longint wb, longint vmax, longint al, longint sl,
                             longint slew, longint dt);
    write_reg(vks_pkg::CfgWheelBase, wb);
    write_reg(vks_pkg::CfgSpeedLimit, vmax);
    write_reg(vks_pkg::CfgAccelLimit, al);
    write_reg(vks_pkg::CfgSteerLimit, sl);
    write_reg(vks_pkg::CfgSlewRate, slew);
    write_reg(vks_pkg::CfgTimeStep, dt);
    cfg_we_i <= 0;
  endtask

  function automatic logic signed [17:0] rand_cmd();
    case ($urandom_range(9))
      0: return 18'sd0;
      1: return 18'sd65536;
      2: return -18'sd65536;
      3: return 18'(signed'($urandom_range(1310)) - 655);
      4: return 18'($urandom);
      default: return 18'(signed'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  // random phase: bursts of driving with random content
  task automatic run_random(int n);
    logic signed [17:0] spd, str;
    int hold;
    hold = 0;
    for (int i = 0; i < n; i++) begin
      if (hold == 0) begin
        spd = rand_cmd(); str = rand_cmd(); hold = $urandom_range(30);
      end else hold--;
      send_command(spd, str);
    end
  endtask

  initial begin
    logic signed [17:0] edges[7];
    edges = '{18'sd0, 18'sd65536, -18'sd65536, 18'sd655, 18'sd656, 18'h1FFFF, 18'h20000};
    repeat (2) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: command extremes, thresholds, coasting to a stop
    for (int i = 0; i < 7; i++) send_command(edges[i], edges[6 - i]);
    repeat (6) send_command(18'sd65536, 18'sd65536);
    repeat (6) send_command(18'sd0, 18'sd0);
    send_command(-18'sd65536, -18'sd65536);
    send_command(18'sd300, 18'sd10);
    send_command(18'sd0, 18'sd0);
    drain_block();

    // extreme settings: zero wheel base, high limits and big steps, then zero limits and the smallest step
    load_config(0, 1048576, 1048576, 91750, 1048576, 6554);
    run_random(250);
    drain_block();
    load_config(262144, 0, 0, 0, 0, 1);
    run_random(100);
    drain_block();

    send_idle_pct = 81;
    load_config(3277, 1048576, 1048576, 91750, 1048576, 6554);
    run_random(300);
    drain_block();

    send_idle_pct = 0; recv_stall_pct = 81;
    load_config(19661, 196608, 131072, 39322, 163840, 655);
    run_random(300);
    drain_block();

    send_idle_pct = 31; recv_stall_pct = 31;
    load_config($urandom_range(262144, 3277), $urandom_range(1048576),
                $urandom_range(1048576), $urandom_range(91750),
                $urandom_range(1048576), $urandom_range(6554, 1));
    run_random(300);
    drain_block();

    send_idle_pct = 0; recv_stall_pct = 0;
    load_config(8000, 2097151, 2097151, 131071, 2097151, 8191);
    run_random(280);
    drain_block();

    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

`default_nettype wire
